[rtl/stpf_pkg.sv]
// shared types and constants of the stride prefetcher
`default_nettype none

package stpf_pkg;

   // fixed field widths
   localparam int INSTR_ADDR_W = 20;
   localparam int DEGREE_W     = 5;
   localparam int CONF_W       = 4;
   localparam int BW_W         = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 5;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEGREE_MAX = 3'd0,
      CSR_DEGREE_MED = 3'd1,
      CSR_DEGREE_LOW = 3'd2,
      CSR_DEGREE_MIN = 3'd3,
      CSR_CONF_CAP   = 3'd4,
      CSR_CROSS_PAGE = 3'd5
   } csr_idx_type;

   // bandwidth throttle levels
   localparam logic [BW_W-1:0] BW_CANCEL = 4'd15;
   localparam logic [BW_W-1:0] BW_DIV8   = 4'd14;
   localparam logic [BW_W-1:0] BW_DIV4   = 4'd13;
   localparam logic [BW_W-1:0] BW_DIV2   = 4'd11;

   // confidence levels that pick the degree
   localparam logic [CONF_W-1:0] CONF_LVL_MAX = 4'd6;
   localparam logic [CONF_W-1:0] CONF_LVL_MED = 4'd4;
   localparam logic [CONF_W-1:0] CONF_LVL_LOW = 4'd2;
   localparam logic [CONF_W-1:0] CONF_LVL_MIN = 4'd1;
   localparam logic [CONF_W-1:0] CONF_ONE     = 4'd1;

   localparam logic [DEGREE_W-1:0] DEGREE_ONE = 5'd1;

   // configuration registers
   typedef struct packed {
      logic [DEGREE_W-1:0] degree_max;
      logic [DEGREE_W-1:0] degree_med;
      logic [DEGREE_W-1:0] degree_low;
      logic [DEGREE_W-1:0] degree_min;
      logic [CONF_W-1:0]   confidence_cap;
      logic                cross_page_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      degree_max:        5'd4,
      degree_med:        5'd3,
      degree_low:        5'd2,
      degree_min:        5'd1,
      confidence_cap:    4'd7,
      cross_page_enable: 1'b0
   };

   // repeated stride seen by the table, with its new confidence
   typedef struct packed {
      logic              matched;
      logic [CONF_W-1:0] conf;
   } match_type;

   // per-item controls held in the input register
   typedef struct packed {
      logic            tick;
      logic            hit;
      logic [BW_W-1:0] bw;
      logic            queue_ready;
   } ctl_type;

endpackage

`default_nettype wire

[rtl/stpf_ram.sv]
// generic single-write, single-read ram with registered read-first output
`default_nettype none

module stpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read; a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/stpf_table.sv]
// per-instruction stride table: entry lookup, training and write-back
`default_nettype none

module stpf_table import stpf_pkg::*; #(
   parameter int INDEX_BITS      = 8,
   parameter int TAG_BITS        = 12,
   parameter int BLOCK_ADDR_BITS = 48
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       rd_en,
   input  wire logic [INDEX_BITS-1:0]      rd_idx,
   input  wire logic                       upd_en,
   input  wire logic [INDEX_BITS-1:0]      upd_idx,
   input  wire logic [TAG_BITS-1:0]        upd_tag,
   input  wire logic [BLOCK_ADDR_BITS-1:0] upd_blk,
   input  wire logic [CONF_W-1:0]          confidence_cap,
   output match_type                       match,
   output logic      [BLOCK_ADDR_BITS:0]   match_stride
);

   localparam int DEPTH    = 1 << INDEX_BITS;
   localparam int STRIDE_W = BLOCK_ADDR_BITS + 1;

   typedef struct packed {
      logic                       valid;
      logic [TAG_BITS-1:0]        tag;
      logic [BLOCK_ADDR_BITS-1:0] last_block;
      logic [STRIDE_W-1:0]        stride;
      logic [CONF_W-1:0]          conf;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   entry_type             ram_rdata;
   entry_type             ent;
   entry_type             wr_data;
   logic                  wr_en;
   logic                  tag_eq;
   logic [STRIDE_W-1:0]   diff;
   logic [STRIDE_W-1:0]   stride;
   logic [CONF_W:0]       conf_inc;
   logic [CONF_W-1:0]     conf_sat;
   logic [DEPTH-1:0]      written_ff;
   logic [DEPTH-1:0]      written_in;
   logic                  byp_vld_ff;
   logic [INDEX_BITS-1:0] byp_idx_ff;
   entry_type             byp_data_ff;

   stpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (upd_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   // entry view: never-written entries read as zero, last write is forwarded
   always_comb begin
      ent = '0;
      if (written_ff[upd_idx]) begin
         if (byp_vld_ff && (byp_idx_ff == upd_idx)) begin
            ent = byp_data_ff;
         end else begin
            ent = ram_rdata;
         end
      end
   end

   // stride and saturating confidence
   always_comb begin
      tag_eq   = (ent.tag == upd_tag);
      diff     = {1'b0, upd_blk} - {1'b0, ent.last_block};
      stride   = (ent.last_block != '0) ? diff : '0;
      conf_inc = {1'b0, ent.conf} + {{CONF_W{1'b0}}, 1'b1};
      conf_sat = (conf_inc > {1'b0, confidence_cap}) ? confidence_cap : conf_inc[CONF_W-1:0];
   end

   // training of the entry
   always_comb begin
      wr_en      = 1'b0;
      wr_data    = ent;
      written_in = written_ff;
      match      = '0;
      if (upd_en) begin
         wr_en = 1'b1;
         if (!tag_eq) begin
            if (!ent.valid) begin
               // install over an invalid entry
               wr_data.valid      = 1'b1;
               wr_data.tag        = upd_tag;
               wr_data.last_block = upd_blk;
               wr_data.stride     = '0;
               wr_data.conf       = '0;
            end else begin
               wr_data.valid = 1'b0;
            end
         end else begin
            wr_data.valid      = 1'b1;
            wr_data.last_block = upd_blk;
            if (stride != '0) begin
               wr_data.stride = stride;
               if (stride == ent.stride) begin
                  wr_data.conf  = conf_sat;
                  match.matched = 1'b1;
                  match.conf    = conf_sat;
               end else begin
                  wr_data.conf = CONF_ONE;
               end
            end
         end
         written_in[upd_idx] = 1'b1;
      end
   end

   assign match_stride = stride;

   // written bits, forwarding register
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (wr_en) begin
            byp_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byp_idx_ff  <= upd_idx;
         byp_data_ff <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/stpf_look.sv]
// degree selection with bandwidth throttle, and the lookahead issue engine
`default_nettype none

module stpf_look import stpf_pkg::*; #(
   parameter int PAGE_BLOCK_BITS = 6,
   parameter int BLOCK_ADDR_BITS = 48
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire ctl_type                    ctl,
   input  wire cfg_type                    cfg,
   input  wire match_type                  match,
   input  wire logic [BLOCK_ADDR_BITS:0]   match_stride,
   input  wire logic [BLOCK_ADDR_BITS-1:0] blk,
   output logic                            pf_valid,
   output logic      [BLOCK_ADDR_BITS-1:0] pf_block,
   output logic                            busy
);

   localparam int STRIDE_W = BLOCK_ADDR_BITS + 1;

   logic                       look_active_ff;
   logic                       look_active_in;
   logic [BLOCK_ADDR_BITS-1:0] look_block_ff;
   logic [BLOCK_ADDR_BITS-1:0] look_block_in;
   logic [STRIDE_W-1:0]        look_stride_ff;
   logic [STRIDE_W-1:0]        look_stride_in;
   logic [DEGREE_W-1:0]        look_remaining_ff;
   logic [DEGREE_W-1:0]        look_remaining_in;
   logic [DEGREE_W-1:0]        degree;
   logic [DEGREE_W-1:0]        rem_next;
   logic [BLOCK_ADDR_BITS-1:0] next_block;
   logic                       same_page;

   function automatic logic [DEGREE_W-1:0] pick_degree(
      input logic [CONF_W-1:0] conf,
      input logic [BW_W-1:0]   bw,
      input cfg_type           c
   );
      logic [DEGREE_W-1:0] d;
      logic [DEGREE_W-1:0] t;
      if (conf >= c.confidence_cap || conf >= CONF_LVL_MAX) begin
         d = c.degree_max;
      end else if (conf >= CONF_LVL_MED) begin
         d = c.degree_med;
      end else if (conf >= CONF_LVL_LOW) begin
         d = c.degree_low;
      end else if (conf >= CONF_LVL_MIN) begin
         d = c.degree_min;
      end else begin
         d = '0;
      end
      t = d;
      if (d != '0) begin
         if (bw >= BW_CANCEL) begin
            t = '0;
         end else if (bw >= BW_DIV8) begin
            t = d >> 3;
         end else if (bw >= BW_DIV4) begin
            t = d >> 2;
         end else if (bw >= BW_DIV2) begin
            t = d >> 1;
         end
         if (bw < BW_CANCEL && bw >= BW_DIV2 && t == '0) begin
            t = DEGREE_ONE;
         end
      end
      return t;
   endfunction

   // next lookahead block and page check
   always_comb begin
      degree     = pick_degree(match.conf, ctl.bw, cfg);
      next_block = look_block_ff + look_stride_ff[BLOCK_ADDR_BITS-1:0];
      same_page  = (next_block[BLOCK_ADDR_BITS-1:PAGE_BLOCK_BITS] ==
                    look_block_ff[BLOCK_ADDR_BITS-1:PAGE_BLOCK_BITS]);
      rem_next   = look_remaining_ff - DEGREE_ONE;
   end

   // arm on a trained access, issue on a tick
   always_comb begin
      look_active_in    = look_active_ff;
      look_block_in     = look_block_ff;
      look_stride_in    = look_stride_ff;
      look_remaining_in = look_remaining_ff;
      pf_valid          = 1'b0;
      pf_block          = '0;
      if (!ctl.tick) begin
         if (match.matched && degree != '0) begin
            look_active_in    = 1'b1;
            look_block_in     = blk + match_stride[BLOCK_ADDR_BITS-1:0];
            look_stride_in    = match_stride;
            look_remaining_in = degree;
         end
      end else if (look_active_ff) begin
         if (cfg.cross_page_enable || same_page) begin
            if (ctl.queue_ready) begin
               pf_valid          = 1'b1;
               pf_block          = next_block;
               look_block_in     = next_block;
               look_remaining_in = rem_next;
               if (rem_next == '0) begin
                  look_active_in = 1'b0;
               end
            end
         end else begin
            look_active_in = 1'b0;
         end
      end
   end

   assign busy = look_active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         look_active_ff    <= 1'b0;
         look_block_ff     <= '0;
         look_stride_ff    <= '0;
         look_remaining_ff <= '0;
      end else if (adv) begin
         look_active_ff    <= look_active_in;
         look_block_ff     <= look_block_in;
         look_stride_ff    <= look_stride_in;
         look_remaining_ff <= look_remaining_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ip_stride_prefetcher_bw_throttle.sv]
// top level of the instruction-indexed stride prefetcher with bandwidth throttle
//
//   channel  ports                     direction  transfer
//   req      req_valid / req_ready     in         one event or tick per item
//   rsp      rsp_valid / rsp_ready     out        one result per item
//   csr      csr_wr_en                 in         write, no wait, no read-back
//
// An item is taken every cycle while the result register is free or drains;
// its result goes from the input register and the table ram read, both taken
// at acceptance, through training and issue into the output register.
// The table ram port and the output register set the one-item-per-cycle rate.
// A stalled result holds the input register, which then holds req_ready low.
// Reset is synchronous; the table written bits clear at once, no clearing pass.
`default_nettype none

module ip_stride_prefetcher_bw_throttle import stpf_pkg::*; #(
   parameter int INDEX_BITS      = 8,
   parameter int TAG_BITS        = 12,
   parameter int PAGE_BLOCK_BITS = 6,
   parameter int BLOCK_ADDR_BITS = 48
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_func,
   input  wire logic [INSTR_ADDR_W-1:0]    req_instr_addr,
   input  wire logic [BLOCK_ADDR_BITS-1:0] req_block_addr,
   input  wire logic                       req_was_hit,
   input  wire logic [BW_W-1:0]            req_dram_bw_level,
   input  wire logic                       req_queue_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_prefetch_valid,
   output logic      [BLOCK_ADDR_BITS-1:0] rsp_prefetch_block,
   output logic                            rsp_lookahead_busy,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IP_W = (INDEX_BITS + TAG_BITS > INSTR_ADDR_W) ?
                         (INDEX_BITS + TAG_BITS) : INSTR_ADDR_W;

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic [IP_W-1:0]            ip_ext;
   logic                       req_fire;
   logic                       s1_adv;
   logic                       s1_vld_ff;
   ctl_type                    s1_ctl_ff;
   logic [INDEX_BITS-1:0]      s1_idx_ff;
   logic [TAG_BITS-1:0]        s1_tag_ff;
   logic [BLOCK_ADDR_BITS-1:0] s1_blk_ff;
   match_type                  match;
   logic [BLOCK_ADDR_BITS:0]   match_stride;
   logic                       pf_valid;
   logic [BLOCK_ADDR_BITS-1:0] pf_block;
   logic                       busy;
   logic                       rsp_valid_ff;
   logic                       rsp_pf_valid_ff;
   logic [BLOCK_ADDR_BITS-1:0] rsp_pf_block_ff;
   logic                       rsp_busy_ff;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_DEGREE_MAX: cfg_in.degree_max        = csr_wdata;
            CSR_DEGREE_MED: cfg_in.degree_med        = csr_wdata;
            CSR_DEGREE_LOW: cfg_in.degree_low        = csr_wdata;
            CSR_DEGREE_MIN: cfg_in.degree_min        = csr_wdata;
            CSR_CONF_CAP:   cfg_in.confidence_cap    = csr_wdata[CONF_W-1:0];
            CSR_CROSS_PAGE: cfg_in.cross_page_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake and pipeline advance
   assign s1_adv    = s1_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign ip_ext    = IP_W'(req_instr_addr);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff.tick        <= req_func;
         s1_ctl_ff.hit         <= req_was_hit;
         s1_ctl_ff.bw          <= req_dram_bw_level;
         s1_ctl_ff.queue_ready <= req_queue_ready;
         s1_idx_ff             <= ip_ext[INDEX_BITS-1:0];
         s1_tag_ff             <= ip_ext[INDEX_BITS +: TAG_BITS];
         s1_blk_ff             <= req_block_addr;
      end
   end

   stpf_table #(
      .INDEX_BITS      (INDEX_BITS),
      .TAG_BITS        (TAG_BITS),
      .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
   ) u_table (
      .clock          (clock),
      .reset          (reset),
      .rd_en          (req_fire),
      .rd_idx         (ip_ext[INDEX_BITS-1:0]),
      .upd_en         (s1_adv && !s1_ctl_ff.tick && !s1_ctl_ff.hit),
      .upd_idx        (s1_idx_ff),
      .upd_tag        (s1_tag_ff),
      .upd_blk        (s1_blk_ff),
      .confidence_cap (cfg_ff.confidence_cap),
      .match          (match),
      .match_stride   (match_stride)
   );

   stpf_look #(
      .PAGE_BLOCK_BITS (PAGE_BLOCK_BITS),
      .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
   ) u_look (
      .clock        (clock),
      .reset        (reset),
      .adv          (s1_adv),
      .ctl          (s1_ctl_ff),
      .cfg          (cfg_ff),
      .match        (match),
      .match_stride (match_stride),
      .blk          (s1_blk_ff),
      .pf_valid     (pf_valid),
      .pf_block     (pf_block),
      .busy         (busy)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pf_valid_ff <= pf_valid;
         rsp_pf_block_ff <= pf_block;
         rsp_busy_ff     <= busy;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prefetch_valid = rsp_pf_valid_ff;
   assign rsp_prefetch_block = rsp_pf_block_ff;
   assign rsp_lookahead_busy = rsp_busy_ff;

endmodule

`default_nettype wire

[rtl/stpf_checker.sv]
// port-level checks of the prefetcher result channel, bound to the top level
`default_nettype none

module stpf_checker #(
   parameter int BLOCK_ADDR_BITS = 48
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_prefetch_valid,
   input wire logic [BLOCK_ADDR_BITS-1:0] rsp_prefetch_block,
   input wire logic                       rsp_lookahead_busy
);

   // no result straight after reset
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("result shown right after reset");

   // a stalled result holds
   property p_stall_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prefetch_valid) &&
            $stable(rsp_prefetch_block) && $stable(rsp_lookahead_busy);
   endproperty
   a_stall_hold: assert property (p_stall_hold)
      else $error("stalled result changed");

   // no prefetch means a zero block address
   property p_idle_block_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_prefetch_valid |-> rsp_prefetch_block == '0;
   endproperty
   a_idle_block_zero: assert property (p_idle_block_zero)
      else $error("block address set without a prefetch");

endmodule

bind ip_stride_prefetcher_bw_throttle stpf_checker #(
   .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
) u_stpf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_prefetch_valid (rsp_prefetch_valid),
   .rsp_prefetch_block (rsp_prefetch_block),
   .rsp_lookahead_busy (rsp_lookahead_busy)
);

`default_nettype wire

[tb/tb.sv]
// self-checking testbench of the stride prefetcher with bandwidth throttle
module tb;
   import stpf_pkg::*;

   localparam int INDEX_BITS             = 8;
   localparam int TAG_BITS               = 12;
   localparam int PAGE_BLOCK_BITS        = 6;
   localparam int BLOCK_ADDR_BITS        = 48;
   localparam int TABLE_DEPTH            = 1 << INDEX_BITS;
   localparam int NUM_STREAMS            = 8;
   localparam int NUM_PHASES             = 6;
   localparam int RANDOM_ITEMS_PER_PHASE = 118;
   localparam int HOLD_OFF_CYCLES        = 300;
   localparam int DRAIN_CYCLES           = 8;
   localparam int WATCHDOG_LIMIT         = 3000;

   // indexes past the register list, writes there are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam bit FUNC_ACCESS = 1'b0;
   localparam bit FUNC_TICK   = 1'b1;

   typedef logic [BLOCK_ADDR_BITS-1:0] blk_type;
   typedef logic [BLOCK_ADDR_BITS:0]   stride_type;

   typedef struct {
      bit                      func;
      logic [INSTR_ADDR_W-1:0] instr_addr;
      blk_type                 block_addr;
      bit                      was_hit;
      logic [BW_W-1:0]         bw;
      bit                      queue_ready;
   } pf_req_type;

   typedef struct {
      logic    prefetch_valid;
      blk_type prefetch_block;
      logic    lookahead_busy;
   } pf_rsp_type;

   // stride table and lookahead predictor plus the queue of expected results
   class prefetch_scoreboard;
      cfg_type             cfg;
      logic [TAG_BITS-1:0] tag_mem [TABLE_DEPTH];
      bit                  valid_mem [TABLE_DEPTH];
      blk_type             last_blk_mem [TABLE_DEPTH];
      stride_type          stride_mem [TABLE_DEPTH];
      logic [CONF_W-1:0]   conf_mem [TABLE_DEPTH];
      bit                  look_active;
      blk_type             look_block;
      stride_type          look_stride;
      logic [DEGREE_W-1:0] look_remaining;
      pf_rsp_type          expected_prefetches [$];
      int                  errors;

      function new();
         int i;
         cfg = CFG_RESET;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            tag_mem[i]      = '0;
            valid_mem[i]    = 1'b0;
            last_blk_mem[i] = '0;
            stride_mem[i]   = '0;
            conf_mem[i]     = '0;
         end
         look_active    = 1'b0;
         look_block     = '0;
         look_stride    = '0;
         look_remaining = '0;
         errors         = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEGREE_MAX: cfg.degree_max        = val;
            CSR_DEGREE_MED: cfg.degree_med        = val;
            CSR_DEGREE_LOW: cfg.degree_low        = val;
            CSR_DEGREE_MIN: cfg.degree_min        = val;
            CSR_CONF_CAP:   cfg.confidence_cap    = val[CONF_W-1:0];
            CSR_CROSS_PAGE: cfg.cross_page_enable = val[0];
            default: ;
         endcase
      endfunction

      // degree from confidence, then cut down by bandwidth pressure
      function int unsigned throttled_degree(int unsigned conf, logic [BW_W-1:0] bw);
         int unsigned d;
         if (conf >= cfg.confidence_cap || conf >= CONF_LVL_MAX) d = cfg.degree_max;
         else if (conf >= CONF_LVL_MED) d = cfg.degree_med;
         else if (conf >= CONF_LVL_LOW) d = cfg.degree_low;
         else if (conf >= CONF_LVL_MIN) d = cfg.degree_min;
         else d = 0;
         if (d > 0) begin
            if (bw >= BW_CANCEL) d = 0;
            else if (bw >= BW_DIV8) d = d / 8;
            else if (bw >= BW_DIV4) d = d / 4;
            else if (bw >= BW_DIV2) d = d / 2;
            if (bw < BW_CANCEL && bw >= BW_DIV2 && d < 1) d = 1;
         end
         return d;
      endfunction

      // table update for a cache access, may arm the lookahead
      function void train_on_access(pf_req_type it);
         int unsigned         idx;
         logic [TAG_BITS-1:0] tag;
         stride_type          stride;
         int unsigned         conf;
         int unsigned         deg;
         idx = it.instr_addr[INDEX_BITS-1:0];
         tag = it.instr_addr[INDEX_BITS +: TAG_BITS];
         if (it.was_hit) return;
         // tag conflict: install into an invalid entry, else only invalidate
         if (tag_mem[idx] != tag) begin
            if (!valid_mem[idx]) begin
               tag_mem[idx]      = tag;
               last_blk_mem[idx] = it.block_addr;
               stride_mem[idx]   = '0;
               conf_mem[idx]     = '0;
               valid_mem[idx]    = 1'b1;
            end else begin
               valid_mem[idx] = 1'b0;
            end
            return;
         end
         valid_mem[idx] = 1'b1;
         stride = '0;
         if (last_blk_mem[idx] != '0)
            stride = {1'b0, it.block_addr} - {1'b0, last_blk_mem[idx]};
         if (stride == '0) begin
            last_blk_mem[idx] = it.block_addr;
            return;
         end
         // repeated stride raises confidence and arms the lookahead
         if (stride == stride_mem[idx]) begin
            conf = conf_mem[idx] + 1;
            if (conf > cfg.confidence_cap) conf = cfg.confidence_cap;
            deg = throttled_degree(conf, it.bw);
            if (deg > 0) begin
               look_active    = 1'b1;
               look_block     = it.block_addr + stride[BLOCK_ADDR_BITS-1:0];
               look_stride    = stride;
               look_remaining = deg[DEGREE_W-1:0];
            end
         end else begin
            conf = 1;
         end
         last_blk_mem[idx] = it.block_addr;
         stride_mem[idx]   = stride;
         conf_mem[idx]     = conf[CONF_W-1:0];
      endfunction

      function pf_rsp_type predict_prefetch(pf_req_type it);
         pf_rsp_type r;
         blk_type    next_blk;
         r.prefetch_valid = 1'b0;
         r.prefetch_block = '0;
         if (it.func == FUNC_ACCESS) begin
            train_on_access(it);
         end else if (look_active) begin
            // one lookahead step per tick, stopping at a page edge unless crossing is enabled
            next_blk = look_block + look_stride[BLOCK_ADDR_BITS-1:0];
            if (cfg.cross_page_enable ||
                next_blk[BLOCK_ADDR_BITS-1:PAGE_BLOCK_BITS] ==
                look_block[BLOCK_ADDR_BITS-1:PAGE_BLOCK_BITS]) begin
               if (it.queue_ready) begin
                  r.prefetch_valid = 1'b1;
                  r.prefetch_block = next_blk;
                  look_block       = next_blk;
                  look_remaining   = look_remaining - 1'b1;
               end
               if (look_remaining == '0) look_active = 1'b0;
            end else begin
               look_active = 1'b0;
            end
         end
         r.lookahead_busy = look_active;
         return r;
      endfunction

      function void note_request(pf_req_type it);
         expected_prefetches.push_back(predict_prefetch(it));
      endfunction

      function void check_response(pf_rsp_type got);
         pf_rsp_type want;
         if (expected_prefetches.size() == 0) begin
            $error("result with no item waiting: prefetch_valid %0d prefetch_block %h",
                   got.prefetch_valid, got.prefetch_block);
            errors++;
            return;
         end
         want = expected_prefetches.pop_front();
         if (got.prefetch_valid !== want.prefetch_valid) begin
            $error("prefetch_valid expected %0d actual %0d",
                   want.prefetch_valid, got.prefetch_valid);
            errors++;
         end
         if (got.prefetch_block !== want.prefetch_block) begin
            $error("prefetch_block expected %h actual %h",
                   want.prefetch_block, got.prefetch_block);
            errors++;
         end
         if (got.lookahead_busy !== want.lookahead_busy) begin
            $error("lookahead_busy expected %0d actual %0d",
                   want.lookahead_busy, got.lookahead_busy);
            errors++;
         end
      endfunction

      function int pending();
         return expected_prefetches.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_func;
   logic [INSTR_ADDR_W-1:0]     req_instr_addr;
   logic [BLOCK_ADDR_BITS-1:0]  req_block_addr;
   logic                        req_was_hit;
   logic [BW_W-1:0]             req_dram_bw_level;
   logic                        req_queue_ready;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_prefetch_valid;
   logic [BLOCK_ADDR_BITS-1:0]  rsp_prefetch_block;
   logic                        rsp_lookahead_busy;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   prefetch_scoreboard sb;
   bit                 hold_off_req;
   int                 burst_left;

   // access streams: fixed instruction address, block address walking by a step
   logic [INSTR_ADDR_W-1:0] stream_ip   [NUM_STREAMS];
   blk_type                 stream_blk  [NUM_STREAMS];
   blk_type                 stream_step [NUM_STREAMS];

   ip_stride_prefetcher_bw_throttle #(
      .INDEX_BITS      (INDEX_BITS),
      .TAG_BITS        (TAG_BITS),
      .PAGE_BLOCK_BITS (PAGE_BLOCK_BITS),
      .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_instr_addr     (req_instr_addr),
      .req_block_addr     (req_block_addr),
      .req_was_hit        (req_was_hit),
      .req_dram_bw_level  (req_dram_bw_level),
      .req_queue_ready    (req_queue_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_prefetch_valid (rsp_prefetch_valid),
      .rsp_prefetch_block (rsp_prefetch_block),
      .rsp_lookahead_busy (rsp_lookahead_busy),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic blk_type random_block();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[BLOCK_ADDR_BITS-1:0];
   endfunction

   // mostly small strides either way, a few huge ones
   function automatic blk_type new_step();
      int      r;
      blk_type s;
      r = $urandom_range(0, 99);
      if (r < 70) s = BLOCK_ADDR_BITS'($urandom_range(1, 4));
      else if (r < 85) s = BLOCK_ADDR_BITS'($urandom_range(5, 40));
      else s = random_block();
      if ($urandom_range(0, 1)) s = -s;
      return s;
   endfunction

   // last two streams share a table index with the first two, other tag
   function automatic void init_streams();
      int s;
      for (s = 0; s < NUM_STREAMS; s++) begin
         stream_ip[s]   = INSTR_ADDR_W'($urandom_range(0, (1 << INSTR_ADDR_W) - 1));
         stream_blk[s]  = random_block();
         stream_step[s] = new_step();
      end
      for (s = NUM_STREAMS - 2; s < NUM_STREAMS; s++)
         stream_ip[s][INDEX_BITS-1:0] = stream_ip[s-(NUM_STREAMS-2)][INDEX_BITS-1:0];
   endfunction

   function automatic pf_req_type random_request();
      pf_req_type it;
      int         r;
      int         s;
      it.func        = FUNC_ACCESS;
      it.instr_addr  = INSTR_ADDR_W'($urandom_range(0, (1 << INSTR_ADDR_W) - 1));
      it.block_addr  = random_block();
      it.was_hit     = 1'($urandom_range(0, 1));
      it.bw          = BW_W'($urandom_range(0, 15));
      it.queue_ready = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         it.func        = FUNC_TICK;
         it.queue_ready = ($urandom_range(0, 3) != 0);
      end else if (r < 85) begin
         // next access of a stream, now and then with a new step
         s = $urandom_range(0, NUM_STREAMS - 1);
         if ($urandom_range(0, 9) == 0) stream_step[s] = new_step();
         stream_blk[s]  = stream_blk[s] + stream_step[s];
         it.instr_addr  = stream_ip[s];
         it.block_addr  = stream_blk[s];
         it.was_hit     = ($urandom_range(0, 11) == 0);
         if ($urandom_range(0, 2) == 0) it.bw = BW_W'($urandom_range(BW_DIV2, BW_CANCEL));
         else it.bw = BW_W'($urandom_range(0, BW_DIV2 - 1));
      end else begin
         it.func = 1'($urandom_range(0, 1));
      end
      return it;
   endfunction

   function automatic pf_req_type access_item(logic [INSTR_ADDR_W-1:0] ip, blk_type blk,
                                              logic [BW_W-1:0] bw, bit hit);
      pf_req_type it;
      it.func        = FUNC_ACCESS;
      it.instr_addr  = ip;
      it.block_addr  = blk;
      it.was_hit     = hit;
      it.bw          = bw;
      it.queue_ready = 1'b0;
      return it;
   endfunction

   function automatic pf_req_type tick_item(bit qr);
      pf_req_type it;
      it.func        = FUNC_TICK;
      it.instr_addr  = '0;
      it.block_addr  = '0;
      it.was_hit     = 1'b0;
      it.bw          = '0;
      it.queue_ready = qr;
      return it;
   endfunction

   // sender gap: mostly none or short, a few long, now and then a burst
   function automatic int next_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(20, 50);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(pf_req_type it, int gap);
      req_valid         <= 1'b1;
      req_func          <= it.func;
      req_instr_addr    <= it.instr_addr;
      req_block_addr    <= it.block_addr;
      req_was_hit       <= it.was_hit;
      req_dram_bw_level <= it.bw;
      req_queue_ready   <= it.queue_ready;
      do @(posedge clock); while (!req_ready);
      sb.note_request(it);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every expected result, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all registers back to back, spare indexes with junk first
   task automatic apply_config(cfg_type c);
      logic [CSR_IDX_W-1:0]  idx_list [8];
      logic [CSR_DATA_W-1:0] data_list [8];
      int                    i;
      idx_list  = '{CSR_SPARE_6, CSR_SPARE_7, CSR_DEGREE_MAX, CSR_DEGREE_MED,
                    CSR_DEGREE_LOW, CSR_DEGREE_MIN, CSR_CONF_CAP, CSR_CROSS_PAGE};
      data_list = '{CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                    c.degree_max, c.degree_med, c.degree_low, c.degree_min,
                    {1'($urandom), c.confidence_cap},
                    {4'($urandom), c.cross_page_enable}};
      for (i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
         sb.write_reg(idx_list[i], data_list[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // result monitor
   always @(posedge clock) begin
      pf_rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.prefetch_valid = rsp_prefetch_valid;
         got.prefetch_block = rsp_prefetch_block;
         got.lookahead_busy = rsp_lookahead_busy;
         sb.check_response(got);
      end
   end

   // receiver: random stalls, bursts of ready, and one long hold-off on request
   initial begin
      int r;
      int len;
      bit on;
      rsp_ready <= 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            on  = 1'b0;
            len = HOLD_OFF_CYCLES;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               on  = 1'b0;
               len = $urandom_range(1, 3);
            end else if (r < 20) begin
               on  = 1'b0;
               len = $urandom_range(10, 40);
            end else if (r < 35) begin
               on  = 1'b1;
               len = $urandom_range(30, 80);
            end else begin
               on  = 1'b1;
               len = $urandom_range(1, 8);
            end
         end
         rsp_ready <= on;
         repeat (len) @(posedge clock);
      end
   end

   // watchdog on cycles with no handshake on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAIL ip_stride_prefetcher_bw_throttle");
      $finish;
   end

   // main sequence
   initial begin
      pf_req_type directed_items [$];
      cfg_type    phase_cfg;
      int         p;
      int         n;
      sb                = new();
      hold_off_req      = 1'b0;
      burst_left        = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_func          <= FUNC_ACCESS;
      req_instr_addr    <= '0;
      req_block_addr    <= '0;
      req_was_hit       <= 1'b0;
      req_dram_bw_level <= '0;
      req_queue_ready   <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_DEGREE_MAX;
      csr_wdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero block address keeps stride zero, then a stride of one arms and drains
      directed_items.push_back(access_item(20'h00005, 48'h0, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h00005, 48'h100, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h00005, 48'h101, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h00005, 48'h102, 4'd0, 1'b0));
      directed_items.push_back(tick_item(1'b0));
      directed_items.push_back(tick_item(1'b1));
      directed_items.push_back(tick_item(1'b1));
      directed_items.push_back(tick_item(1'b1));
      // tag conflict on a valid entry, then install, then an ignored hit
      directed_items.push_back(access_item(20'h12305, 48'hABC, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h12305, 48'hABC, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h12305, 48'hDEF, 4'd0, 1'b1));
      // lookahead that runs into a page edge
      directed_items.push_back(access_item(20'h00007, 48'h139, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h00007, 48'h13B, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'h00007, 48'h13D, 4'd0, 1'b0));
      directed_items.push_back(tick_item(1'b1));
      // bandwidth cancel, then divide by eight with the floor of one
      directed_items.push_back(access_item(20'h00007, 48'h13F, BW_CANCEL, 1'b0));
      directed_items.push_back(access_item(20'h00007, 48'h141, BW_DIV8, 1'b0));
      directed_items.push_back(tick_item(1'b1));
      // negative stride under halving
      directed_items.push_back(access_item(20'h00009, 48'h50, BW_DIV2, 1'b0));
      directed_items.push_back(access_item(20'h00009, 48'h4F, BW_DIV2, 1'b0));
      directed_items.push_back(access_item(20'h00009, 48'h4E, BW_DIV2, 1'b0));
      directed_items.push_back(tick_item(1'b1));
      // all-ones addresses with quartering
      directed_items.push_back(access_item(20'hFFFFF, 48'hFFFF_FFFF_FFFF, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'hFFFFF, 48'hFFFF_FFFF_FFFE, 4'd0, 1'b0));
      directed_items.push_back(access_item(20'hFFFFF, 48'hFFFF_FFFF_FFFD, BW_DIV4, 1'b0));
      foreach (directed_items[i]) send_request(directed_items[i], next_gap());

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: phase_cfg = '{5'd16, 5'd16, 5'd16, 5'd16, 4'd15, 1'b1};
            1: phase_cfg = '{5'd0, 5'd0, 5'd0, 5'd0, 4'd1, 1'b0};
            2: phase_cfg = '{5'd31, 5'd20, 5'd9, 5'd5, 4'd0, 1'b1};
            3: phase_cfg = '{5'd8, 5'd5, 5'd3, 5'd1, 4'd3, 1'b0};
            4: phase_cfg = CFG_RESET;
            default: begin
               phase_cfg.degree_max        = DEGREE_W'($urandom_range(0, 16));
               phase_cfg.degree_med        = DEGREE_W'($urandom_range(0, 16));
               phase_cfg.degree_low        = DEGREE_W'($urandom_range(0, 16));
               phase_cfg.degree_min        = DEGREE_W'($urandom_range(0, 16));
               phase_cfg.confidence_cap    = CONF_W'($urandom_range(1, 15));
               phase_cfg.cross_page_enable = 1'($urandom_range(0, 1));
            end
         endcase
         apply_config(phase_cfg);
         init_streams();
         for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 30) hold_off_req = 1'b1;
            send_request(random_request(), next_gap());
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS ip_stride_prefetcher_bw_throttle");
      else
         $display("FAIL ip_stride_prefetcher_bw_throttle");
      $finish;
   end

endmodule
